// File: rtl/text_display_terminal_unit_defines.svh
// ----------------------------------------------------------------------------
// text_display_terminal_unit_defines
// Assertion macros used by the checker of the terminal unit.
// ----------------------------------------------------------------------------
`ifndef TEXT_DISPLAY_TERMINAL_UNIT_DEFINES_SVH
`define TEXT_DISPLAY_TERMINAL_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TDT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TDT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tdt_pkg.sv
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared constants, character codes and helpers of the terminal unit.
// ----------------------------------------------------------------------------
package tdt_pkg;

  localparam int TDT_ROWS = 2;
  localparam int TDT_COLS = 16;

  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_FF       = 8'h0C;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_BL_ON    = 8'h11;
  localparam logic [7:0] CH_BL_OFF   = 8'h13;
  localparam logic [7:0] CH_SPACE    = 8'h20;

  localparam logic UPD_BACKLIGHT = 1'b0;
  localparam logic UPD_CELL      = 1'b1;

  function automatic logic is_printable(input logic [7:0] c);
    is_printable = ((c >= 8'h20) && (c <= 8'h7E)) || (c >= 8'hA0);
  endfunction

endpackage

// File: rtl/tdt_store.sv
// ----------------------------------------------------------------------------
// tdt_store
// Character store with one write and one registered read port. Per-cell
// valid bits make unwritten or cleared cells read as a space.
// ----------------------------------------------------------------------------
module tdt_store
  import tdt_pkg::*;
#(
  parameter int ROWS = TDT_ROWS,
  parameter int COLS = TDT_COLS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clr,
  input  logic                                wr_en,
  input  logic [$clog2(ROWS*COLS)-1:0]        wr_addr,
  input  logic [7:0]                          wr_data,
  input  logic                                rd_en,
  input  logic [$clog2(ROWS*COLS)-1:0]        rd_addr,
  output logic [7:0]                          rd_data
);

  localparam int Depth = ROWS * COLS;

  logic [7:0]       mem [Depth];
  logic [Depth-1:0] vld_r;
  logic [7:0]       rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : CH_SPACE;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/text_display_terminal_unit.sv
// ----------------------------------------------------------------------------
// text_display_terminal_unit
// Character terminal: a cursor over a ROWS x COLS store, control byte
// handling, backlight commands and a full refresh stream on end of write.
// ----------------------------------------------------------------------------
// Flow: a byte is registered when taken and applied in the next cycle; a byte
//   with no result frees the input once ST_EXEC returns to ST_IDLE, and a
//   backlight command passes ST_EXEC and ST_BL before it is registered.
//   A new byte is held off until the last is through; an end-of-write refresh
//   reads each of the ROWS*COLS cells through the store's single read port.
// Reset: synchronous, active low; clears cursor, sequencer and output valid,
//   and marks every cell as a space.
// ----------------------------------------------------------------------------
module text_display_terminal_unit
  import tdt_pkg::*;
#(
  parameter int ROWS = TDT_ROWS,
  parameter int COLS = TDT_COLS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_char_code,
  input  logic                                in_end_of_write,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_update_type,
  output logic                                out_backlight_on,
  output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] out_cell_row,
  output logic [$clog2(COLS)-1:0]             out_cell_col,
  output logic [7:0]                          out_cell_char,
  output logic                                out_last
);

  localparam int RowW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CurRW = $clog2(ROWS + 1);
  localparam int ColW  = $clog2(COLS);
  localparam int AddrW = $clog2(ROWS * COLS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BL,
    ST_READ,
    ST_LOAD
  } state_t;

  state_t          state_r, state_nxt;
  logic [7:0]      ch_r, ch_nxt;
  logic            eow_r, eow_nxt;
  logic [CurRW-1:0] cur_row_r, cur_row_nxt;
  logic [ColW-1:0] cur_col_r, cur_col_nxt;
  logic [RowW-1:0] rf_row_r, rf_row_nxt;
  logic [ColW-1:0] rf_col_r, rf_col_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            out_type_r, out_type_nxt;
  logic            out_bl_r, out_bl_nxt;
  logic [RowW-1:0] out_row_r, out_row_nxt;
  logic [ColW-1:0] out_col_r, out_col_nxt;
  logic [7:0]      out_char_r, out_char_nxt;
  logic            out_last_r, out_last_nxt;

  logic            out_free;
  logic            st_clr, st_wr_en, st_rd_en;
  logic [RowW-1:0] sel_row;
  logic [ColW-1:0] sel_col;
  logic [AddrW-1:0] addr;
  logic [7:0]      rd_data;
  logic            row_live;
  logic            rf_final;

  assign out_free = !out_valid_r || !out_stall;
  assign row_live = (cur_row_r < CurRW'(ROWS));
  assign rf_final = (rf_row_r == RowW'(ROWS - 1)) && (rf_col_r == ColW'(COLS - 1));

  assign sel_row = (state_r == ST_EXEC) ? RowW'(cur_row_r) : rf_row_r;
  assign sel_col = (state_r == ST_EXEC) ? cur_col_r : rf_col_r;
  assign addr    = AddrW'(32'(sel_row) * 32'(COLS) + 32'(sel_col));

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    eow_nxt       = eow_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    rf_row_nxt    = rf_row_r;
    rf_col_nxt    = rf_col_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_type_nxt  = out_type_r;
    out_bl_nxt    = out_bl_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    st_clr        = 1'b0;
    st_wr_en      = 1'b0;
    st_rd_en      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ch_nxt    = in_char_code;
          eow_nxt   = in_end_of_write;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rf_row_nxt = '0;
        rf_col_nxt = '0;
        if (is_printable(ch_r) && row_live) begin
          st_wr_en = 1'b1;
          if (cur_col_r == ColW'(COLS - 1)) begin
            cur_col_nxt = '0;
            cur_row_nxt = cur_row_r + 1'b1;
          end else begin
            cur_col_nxt = cur_col_r + 1'b1;
          end
        end else begin
          case (ch_r)
            CH_BS: begin
              if (cur_col_r != '0) begin
                cur_col_nxt = cur_col_r - 1'b1;
              end else if (cur_row_r != '0) begin
                cur_col_nxt = ColW'(COLS - 1);
                cur_row_nxt = cur_row_r - 1'b1;
              end
            end
            CH_TAB: begin
              if (cur_col_r == ColW'(COLS - 1)) begin
                cur_col_nxt = '0;
                if (row_live) cur_row_nxt = cur_row_r + 1'b1;
              end else begin
                cur_col_nxt = cur_col_r + 1'b1;
              end
            end
            CH_LF: begin
              cur_col_nxt = '0;
              if (row_live) cur_row_nxt = cur_row_r + 1'b1;
            end
            CH_FF: begin
              cur_col_nxt = '0;
              cur_row_nxt = '0;
              st_clr      = 1'b1;
            end
            CH_CR: begin
              cur_col_nxt = '0;
            end
            default: begin
            end
          endcase
        end
        if (ch_r == CH_BL_ON || ch_r == CH_BL_OFF) begin
          state_nxt = ST_BL;
        end else if (eow_r) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_type_nxt  = UPD_BACKLIGHT;
          out_bl_nxt    = (ch_r == CH_BL_ON);
          out_row_nxt   = '0;
          out_col_nxt   = '0;
          out_char_nxt  = '0;
          out_last_nxt  = !eow_r;
          state_nxt     = eow_r ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        st_rd_en  = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_type_nxt  = UPD_CELL;
          out_bl_nxt    = 1'b0;
          out_row_nxt   = rf_row_r;
          out_col_nxt   = rf_col_r;
          out_char_nxt  = rd_data;
          out_last_nxt  = rf_final;
          if (rf_final) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_READ;
            if (rf_col_r == ColW'(COLS - 1)) begin
              rf_col_nxt = '0;
              rf_row_nxt = rf_row_r + 1'b1;
            end else begin
              rf_col_nxt = rf_col_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ch_r       <= ch_nxt;
    eow_r      <= eow_nxt;
    rf_row_r   <= rf_row_nxt;
    rf_col_r   <= rf_col_nxt;
    out_type_r <= out_type_nxt;
    out_bl_r   <= out_bl_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  tdt_store #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (st_clr),
    .wr_en   (st_wr_en),
    .wr_addr (addr),
    .wr_data (ch_r),
    .rd_en   (st_rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_update_type  = out_type_r;
  assign out_backlight_on = out_bl_r;
  assign out_cell_row     = out_row_r;
  assign out_cell_col     = out_col_r;
  assign out_cell_char    = out_char_r;
  assign out_last         = out_last_r;

endmodule

// File: rtl/tdt_checker.sv
// ----------------------------------------------------------------------------
// tdt_checker
// Port-level checks of the terminal unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_display_terminal_unit_defines.svh"

module tdt_checker
  import tdt_pkg::*;
#(
  parameter int ROWS = TDT_ROWS,
  parameter int COLS = TDT_COLS
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [7:0]                          in_char_code,
  input logic                                in_end_of_write,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                out_update_type,
  input logic                                out_backlight_on,
  input logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] out_cell_row,
  input logic [$clog2(COLS)-1:0]             out_cell_col,
  input logic [7:0]                          out_cell_char,
  input logic                                out_last
);

  localparam int RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ColW = $clog2(COLS);

  logic in_xfer;
  logic final_cell;

  assign in_xfer    = in_valid && !in_stall;
  assign final_cell = out_valid && (out_update_type == UPD_CELL) &&
                      (out_cell_row == RowW'(ROWS - 1)) &&
                      (out_cell_col == ColW'(COLS - 1));

  `TDT_ASSERT(a_busy_after_xfer, in_xfer |=> in_stall, "input not held off after transfer")
  `TDT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_cell_char) && $stable(out_last), "stalled result changed")
  `TDT_ASSERT(a_bl_zero, out_valid && (out_update_type == UPD_BACKLIGHT) |-> (out_cell_char == 8'h00) && (out_cell_col == '0) && (out_cell_row == '0), "backlight command carries cell data")
  `TDT_ASSERT(a_final_cell_last, final_cell |-> out_last, "final cell of refresh not marked last")
  `TDT_ASSERT_ALWAYS(a_reset_clears, $past(!rst_n) |-> !out_valid, "result valid after reset")

endmodule

bind text_display_terminal_unit tdt_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_tdt_checker (.*);

// File: bench/text_display_terminal_unit_checker.sv
// ----------------------------------------------------------------------------
// text_display_terminal_unit_checker
// Watches both channels of the terminal unit. Each input transfer is run
// through a cycle-free model of the cursor and character store, and the
// resulting backlight commands and cell refreshes are queued. Each output
// transfer is compared field by field with the oldest queued update.
// ----------------------------------------------------------------------------
module text_display_terminal_unit_checker
  import tdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_write,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_update_type,
  input  logic       out_backlight_on,
  input  logic       out_cell_row,
  input  logic [3:0] out_cell_col,
  input  logic [7:0] out_cell_char,
  input  logic       out_last,
  output int         mismatch_total,
  output int         pending_updates
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       kind;
    logic       light;
    logic       row;
    logic [3:0] col;
    logic [7:0] glyph;
    logic       last;
  } display_update_t;

  logic [7:0]      screen [TDT_ROWS*TDT_COLS];
  logic [1:0]      cur_row;
  logic [4:0]      cur_col;
  display_update_t expected_updates [$];

  function automatic logic is_glyph(input logic [7:0] c);
    return (c >= 8'h20 && c <= 8'h7E) || (c >= 8'hA0);
  endfunction

  function automatic display_update_t backlight_cmd(input logic on);
    display_update_t u;
    u = '0;
    u.kind  = UPD_BACKLIGHT;
    u.light = on;
    return u;
  endfunction

  task automatic clear_screen();
    for (int i = 0; i < TDT_ROWS*TDT_COLS; i++) screen[i] = CH_SPACE;
  endtask

  task automatic predict_terminal_byte(input logic [7:0] c, input logic eow);
    display_update_t batch [$];
    display_update_t u;
    if (is_glyph(c) && cur_row < TDT_ROWS) begin
      screen[cur_row*TDT_COLS + cur_col] = c;
      cur_col = cur_col + 5'd1;
    end else begin
      case (c)
        CH_BS: begin
          if (cur_col > 0) begin
            cur_col = cur_col - 5'd1;
          end else if (cur_row > 0) begin
            cur_col = 5'(TDT_COLS - 1);
            cur_row = cur_row - 2'd1;
          end
        end
        CH_TAB: cur_col = cur_col + 5'd1;
        CH_LF: begin
          cur_col = '0;
          if (cur_row < TDT_ROWS) cur_row = cur_row + 2'd1;
        end
        CH_FF: begin
          cur_col = '0;
          cur_row = '0;
          clear_screen();
        end
        CH_CR: cur_col = '0;
        CH_BL_ON: batch.push_back(backlight_cmd(1'b1));
        CH_BL_OFF: batch.push_back(backlight_cmd(1'b0));
        default: ;
      endcase
    end
    if (cur_col >= TDT_COLS) begin
      cur_col = '0;
      if (cur_row < TDT_ROWS) cur_row = cur_row + 2'd1;
    end
    if (eow) begin
      for (int r = 0; r < TDT_ROWS; r++) begin
        for (int k = 0; k < TDT_COLS; k++) begin
          u = '0;
          u.kind  = UPD_CELL;
          u.row   = r[0];
          u.col   = k[3:0];
          u.glyph = screen[r*TDT_COLS + k];
          batch.push_back(u);
        end
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) expected_updates.push_back(batch[i]);
  endtask

  task automatic check_update(input display_update_t got);
    display_update_t want;
    if (expected_updates.size() == 0) begin
      mismatch_total++;
      if (mismatch_total <= 10)
        $display("%0t: unexpected update type=%0d bl=%0d row=%0d col=%0d char=%02h last=%0d",
                 $realtime, got.kind, got.light, got.row, got.col, got.glyph, got.last);
      return;
    end
    want = expected_updates.pop_front();
    if (got !== want) begin
      mismatch_total++;
      if (mismatch_total <= 10) begin
        $display("%0t: mismatch expected type=%0d bl=%0d row=%0d col=%0d char=%02h last=%0d",
                 $realtime, want.kind, want.light, want.row, want.col, want.glyph,
                 want.last);
        $display("    got type=%0d bl=%0d row=%0d col=%0d char=%02h last=%0d",
                 got.kind, got.light, got.row, got.col, got.glyph, got.last);
      end
    end
  endtask

  initial begin
    mismatch_total  = 0;
    pending_updates = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_screen();
      cur_row = '0;
      cur_col = '0;
      expected_updates.delete();
    end else begin
      if (in_valid && !in_stall) predict_terminal_byte(in_char_code, in_end_of_write);
      if (out_valid && !out_stall)
        check_update({out_update_type, out_backlight_on, out_cell_row, out_cell_col,
                      out_cell_char, out_last});
    end
    pending_updates = expected_updates.size();
  end

endmodule

// File: bench/text_display_terminal_unit_tb.sv
// ----------------------------------------------------------------------------
// text_display_terminal_unit_tb
// Drives the terminal unit with a directed set of bytes covering every control
// code, the printable edges at 7E/7F, 9F/A0 and FF, and the parked cursor, then
// with random text streams mixed with control bytes and end-of-write refreshes.
// Both channels idle and stall at random; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module text_display_terminal_unit_tb
  import tdt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_code;
  logic       in_end_of_write;
  logic       out_valid;
  logic       out_stall;
  logic       out_update_type;
  logic       out_backlight_on;
  logic       out_cell_row;
  logic [3:0] out_cell_col;
  logic [7:0] out_cell_char;
  logic       out_last;
  int         mismatch_total;
  int         pending_updates;
  logic       steady_flow;

  text_display_terminal_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_end_of_write  (in_end_of_write),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_update_type  (out_update_type),
    .out_backlight_on (out_backlight_on),
    .out_cell_row     (out_cell_row),
    .out_cell_col     (out_cell_col),
    .out_cell_char    (out_cell_char),
    .out_last         (out_last)
  );

  text_display_terminal_unit_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_end_of_write  (in_end_of_write),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_update_type  (out_update_type),
    .out_backlight_on (out_backlight_on),
    .out_cell_row     (out_cell_row),
    .out_cell_col     (out_cell_col),
    .out_cell_char    (out_cell_char),
    .out_last         (out_last),
    .mismatch_total   (mismatch_total),
    .pending_updates  (pending_updates)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h20, 8'h7E));
      return 8'($urandom_range(8'hA0, 8'hFF));
    end
    if (r < 62) return CH_LF;
    if (r < 67) return CH_CR;
    if (r < 71) return CH_TAB;
    if (r < 76) return CH_BS;
    if (r < 79) return CH_FF;
    if (r < 83) return CH_BL_ON;
    if (r < 87) return CH_BL_OFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eow);
    int gap;
    gap = steady_flow ? 0 : pick_idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        = 1'b1;
    in_char_code    = c;
    in_end_of_write = eow;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : stall_gen
    int busy_left;
    int free_left;
    busy_left = 0;
    free_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (steady_flow) begin
        out_stall = 1'b0;
      end else if (free_left > 0) begin
        out_stall = 1'b0;
        free_left--;
      end else if (busy_left > 0) begin
        out_stall = 1'b1;
        busy_left--;
      end else begin
        busy_left = pick_idle_len();
        free_left = $urandom_range(1, 12);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    steady_flow     = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_char_code    = 8'h00;
    in_end_of_write = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_byte(CH_BS, 1'b0);
    send_byte(CH_BL_ON, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_BS, 1'b0);
    send_byte(CH_CR, 1'b1);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_BS, 1'b0);
    send_byte(8'h7A, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(8'h51, 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_BL_OFF, 1'b1);
    send_byte(CH_BS, 1'b0);
    send_byte(CH_BS, 1'b0);
    send_byte(CH_FF, 1'b1);

    for (int i = 0; i < 288; i++) begin
      if (i % 48 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      send_byte(pick_byte(), $urandom_range(0, 99) < 8);
    end

    @(negedge clk);
    in_valid    = 1'b0;
    steady_flow = 1'b0;
    while (pending_updates != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatch_total == 0 && pending_updates == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
